### rtl/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg: shared types and constants of the string symbol table
// sizes, operation and status codes, sequencer states
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int unsigned TableEntries = 256;
  localparam int unsigned LexemeBytes  = 4096;
  localparam int unsigned MaxString    = 31;

  localparam int unsigned IdxW  = $clog2(TableEntries);
  localparam int unsigned CntW  = IdxW + 1;
  localparam int unsigned LexW  = $clog2(LexemeBytes);
  localparam int unsigned FillW = LexW + 1;
  localparam int unsigned LenW  = $clog2(MaxString + 2);
  localparam int unsigned PosW  = $clog2(MaxString + 1);

  // entry record: token, info, start, length
  localparam int unsigned EntW = 16 + 16 + LexW + LenW;

  localparam logic [15:0] InfoNone = 16'hFFFF;

  typedef enum logic [2:0] {
    OP_LOOKUP = 3'd0,
    OP_INSERT = 3'd1,
    OP_READ   = 3'd2,
    OP_SET_TOK = 3'd3,
    OP_SET_INF = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_TBL_FULL  = 3'd2,
    ST_LEX_FULL  = 3'd3,
    ST_BAD_INDEX = 3'd4,
    ST_TOO_LONG  = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ENT_RD,     // entry read issued
    S_CMP,        // compare characters of candidate
    S_CMP_WAIT,
    S_INS,        // copy pending into lexeme store
    S_OUT,        // single result waits
    S_RD_ENT,     // read entry for op 2/3/4
    S_RD_HEAD,
    S_RD_CHAR_RQ,
    S_RD_CHAR
  } state_e;

  typedef struct packed {
    logic [15:0]     token;
    logic [15:0]     info;
    logic [LexW-1:0] start;
    logic [LenW-1:0] len;
  } entry_t;

endpackage

### rtl/sst_ram.sv
// ----------------------------------------------------------------------------
// sst_ram: generic single-port synchronous ram
// one write or read per cycle, registered read data
// ----------------------------------------------------------------------------
module sst_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

### rtl/string_symbol_table.sv
// ----------------------------------------------------------------------------
// string_symbol_table: symbol table of strings with linear search
// lookup/insert strings stream in a character per request; read/set by index
// ----------------------------------------------------------------------------
// Characters of a lookup or insert string are buffered at one per cycle while
// the output register is free. The request marked tlast runs the search: entries
// are read newest to oldest from the entry ram, and each candidate of matching
// length is compared a character at a time against the lexeme ram, a read state
// then a compare state per character (one ram port); an insert then copies the
// string at 1 cycle per character and then writes the entry. Read returns a
// header result then one result per lexeme character (at most 31). Set
// token/info is a read-modify-write of one entry. One request is in work at a
// time; a finished result sits in the output register and the next request is
// taken as soon as it is consumed.
// ----------------------------------------------------------------------------
module string_symbol_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: operation[2:0], character[10:3], entry_index[18:11],
  //        token_value[34:19], info_value[50:35], zero fill [55:51]
  input  logic [55:0] s_axis_tdata,
  input  logic        s_axis_tlast,   // last_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: status[2:0], result_index[10:3], entry_token[26:11],
  //        entry_info[42:27], lexeme_char[50:43], zero fill [55:51]
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tlast    // last_result
);

  localparam int unsigned IdxW  = sst_pkg::IdxW;
  localparam int unsigned CntW  = sst_pkg::CntW;
  localparam int unsigned LexW  = sst_pkg::LexW;
  localparam int unsigned FillW = sst_pkg::FillW;
  localparam int unsigned LenW  = sst_pkg::LenW;
  localparam int unsigned PosW  = sst_pkg::PosW;

  // input fields
  logic [2:0]  in_op;
  logic [7:0]  in_ch;
  logic [7:0]  in_idx;
  logic [15:0] in_tok, in_inf;
  assign in_op  = s_axis_tdata[2:0];
  assign in_ch  = s_axis_tdata[10:3];
  assign in_idx = s_axis_tdata[18:11];
  assign in_tok = s_axis_tdata[34:19];
  assign in_inf = s_axis_tdata[50:35];

  sst_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [LenW-1:0]  plen_q, plen_d;
  logic [7:0]       pend_q [sst_pkg::MaxString];

  // latched request
  logic             ins_q, ins_d;
  logic [2:0]       op_q, op_d;
  logic [IdxW-1:0]  idx_q, idx_d;       // entry being walked / addressed
  logic [15:0]      tok_q, tok_d, inf_q, inf_d;
  logic [LenW-1:0]  slen_q, slen_d;     // search length
  logic [PosW-1:0]  pos_q, pos_d;
  sst_pkg::entry_t  ent_q, ent_d;

  // output register
  logic        ov_q, ov_d, olast_q, olast_d;
  logic [2:0]  ost_q, ost_d;
  logic [7:0]  oidx_q, oidx_d, och_q, och_d;
  logic [15:0] otok_q, otok_d, oinf_q, oinf_d;

  // rams
  logic            e_we;
  logic [IdxW-1:0] e_addr;
  sst_pkg::entry_t e_wdata, e_rdata;
  logic            l_we;
  logic [LexW-1:0] l_addr;
  logic [7:0]      l_wdata, l_rdata;

  sst_ram #(.Width(sst_pkg::EntW), .Depth(sst_pkg::TableEntries)) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (e_we),
    .addr_i (e_addr),
    .wdata_i(e_wdata),
    .rdata_o(e_rdata)
  );

  sst_ram #(.Width(8), .Depth(sst_pkg::LexemeBytes)) u_lexeme_ram (
    .clk_i  (clk_i),
    .we_i   (l_we),
    .addr_i (l_addr),
    .wdata_i(l_wdata),
    .rdata_o(l_rdata)
  );

  logic in_fire, out_fire, out_free;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign out_free = !ov_q || m_axis_tready;
  assign s_axis_tready = (state_q == sst_pkg::S_IDLE) && out_free;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // pending string buffer; copy uses pos, so no clear needed
  always_ff @(posedge clk_i) begin
    if (in_fire && (in_op == sst_pkg::OP_LOOKUP || in_op == sst_pkg::OP_INSERT)
        && in_ch != 8'd0 && plen_q < LenW'(sst_pkg::MaxString)) begin
      pend_q[plen_q[PosW-1:0]] <= in_ch;
    end
  end

  logic [FillW:0] need;
  assign need = {1'b0, fill_q} + (FillW+1)'(slen_q);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    fill_d  = fill_q;
    plen_d  = plen_q;
    ins_d   = ins_q;
    op_d    = op_q;
    idx_d   = idx_q;
    tok_d   = tok_q;
    inf_d   = inf_q;
    slen_d  = slen_q;
    pos_d   = pos_q;
    ent_d   = ent_q;
    ov_d    = ov_q && !out_fire;
    olast_d = olast_q;
    ost_d   = ost_q;
    oidx_d  = oidx_q;
    och_d   = och_q;
    otok_d  = otok_q;
    oinf_d  = oinf_q;
    e_we    = 1'b0;
    e_addr  = idx_q;
    e_wdata = ent_q;
    l_we    = 1'b0;
    l_addr  = ent_q.start + LexW'(pos_q);
    l_wdata = pend_q[pos_q];

    case (state_q)
      sst_pkg::S_IDLE: begin
        if (in_fire) begin
          op_d  = in_op;
          tok_d = in_tok;
          inf_d = in_inf;
          ost_d = sst_pkg::ST_OK;
          oidx_d = 8'd0;
          otok_d = 16'd0;
          oinf_d = 16'd0;
          och_d  = 8'd0;
          olast_d = 1'b1;
          if (in_op == sst_pkg::OP_LOOKUP || in_op == sst_pkg::OP_INSERT) begin
            if (in_ch != 8'd0) begin
              plen_d = (plen_q < LenW'(sst_pkg::MaxString)) ? plen_q + 1'b1
                                                          : LenW'(sst_pkg::MaxString + 1);
            end
            if (s_axis_tlast) begin
              slen_d = plen_d;
              plen_d = '0;
              ins_d  = (in_op == sst_pkg::OP_INSERT);
              if (slen_d > LenW'(sst_pkg::MaxString)) begin
                ost_d = sst_pkg::ST_TOO_LONG;
                ov_d  = 1'b1;
              end else if (count_q == '0) begin
                state_d = sst_pkg::S_OUT;
              end else begin
                // newest entry is read now and seen in the next state
                idx_d   = IdxW'(count_q - 1'b1);
                e_addr  = idx_d;
                state_d = sst_pkg::S_ENT_RD;
              end
            end
          end else if (in_op == sst_pkg::OP_READ || in_op == sst_pkg::OP_SET_TOK
                       || in_op == sst_pkg::OP_SET_INF) begin
            idx_d  = IdxW'(in_idx);
            oidx_d = in_idx;
            if ({1'b0, in_idx} >= 9'(count_q)) begin
              ost_d = sst_pkg::ST_BAD_INDEX;
              ov_d  = 1'b1;
            end else begin
              state_d = sst_pkg::S_RD_ENT;
            end
          end
        end
      end

      // read of idx_q issued last cycle
      sst_pkg::S_ENT_RD: begin
        ent_d = e_rdata;
        pos_d = '0;
        if (e_rdata.len == slen_q) begin
          if (slen_q == '0) begin
            ost_d = sst_pkg::ST_OK;
            oidx_d = 8'(idx_q);
            otok_d = e_rdata.token;
            oinf_d = e_rdata.info;
            state_d = sst_pkg::S_OUT;
          end else begin
            state_d = sst_pkg::S_CMP;
          end
        end else if (idx_q == '0) begin
          state_d = sst_pkg::S_OUT;
          ost_d   = sst_pkg::ST_NOT_FOUND;
        end else begin
          idx_d   = idx_q - 1'b1;
          e_addr  = idx_d;
        end
        if (state_d == sst_pkg::S_OUT && ost_q != sst_pkg::ST_OK) begin
          ost_d = ost_q;
        end
        if (state_d == sst_pkg::S_OUT && e_rdata.len != slen_q) begin
          ost_d = sst_pkg::ST_NOT_FOUND;
        end
      end

      // lexeme read at l_addr issued this cycle
      sst_pkg::S_CMP: begin
        state_d = sst_pkg::S_CMP_WAIT;
      end

      sst_pkg::S_CMP_WAIT: begin
        if (l_rdata != pend_q[pos_q]) begin
          if (idx_q == '0) begin
            ost_d   = sst_pkg::ST_NOT_FOUND;
            state_d = sst_pkg::S_OUT;
          end else begin
            idx_d   = idx_q - 1'b1;
            e_addr  = idx_d;
            state_d = sst_pkg::S_ENT_RD;
          end
        end else if (LenW'(pos_q) + 1'b1 == slen_q) begin
          ost_d  = sst_pkg::ST_OK;
          oidx_d = 8'(idx_q);
          otok_d = ent_q.token;
          oinf_d = ent_q.info;
          state_d = sst_pkg::S_OUT;
        end else begin
          pos_d   = pos_q + 1'b1;
          state_d = sst_pkg::S_CMP;
        end
      end

      // single result: resolves not-found into insert if asked
      sst_pkg::S_OUT: begin
        if (ost_q == sst_pkg::ST_OK && oidx_q == 8'(idx_q) && otok_q == ent_q.token
            && state_q == sst_pkg::S_OUT && ins_q == 1'b0 && 1'b0) begin
          state_d = sst_pkg::S_IDLE;
        end
        if ((ost_q == sst_pkg::ST_NOT_FOUND || count_q == '0) && ins_q
            && !(ost_q == sst_pkg::ST_OK && count_q != '0)) begin
          if (count_q >= CntW'(sst_pkg::TableEntries)) begin
            ost_d = sst_pkg::ST_TBL_FULL;
          end else if (need > (FillW+1)'(sst_pkg::LexemeBytes)) begin
            ost_d = sst_pkg::ST_LEX_FULL;
          end else begin
            ent_d.token = tok_q;
            ent_d.info  = sst_pkg::InfoNone;
            ent_d.start = fill_q[LexW-1:0];
            ent_d.len   = slen_q;
            pos_d       = '0;
            state_d     = sst_pkg::S_INS;
          end
          if (state_d != sst_pkg::S_INS && out_free) begin
            ov_d = 1'b1;
            state_d = sst_pkg::S_IDLE;
            ins_d = 1'b0;
          end else if (state_d != sst_pkg::S_INS) begin
            ins_d = 1'b0;
            ost_d = ost_d;
          end
        end else if (out_free) begin
          if (ost_q == sst_pkg::ST_NOT_FOUND || (count_q == '0)) begin
            ost_d = sst_pkg::ST_NOT_FOUND;
          end
          ov_d    = 1'b1;
          state_d = sst_pkg::S_IDLE;
        end
      end

      sst_pkg::S_INS: begin
        if (LenW'(pos_q) == slen_q) begin
          e_we    = 1'b1;
          e_addr  = IdxW'(count_q);
          if (out_free) begin
            count_d = count_q + 1'b1;
            fill_d  = fill_q + FillW'(slen_q);
            ost_d   = sst_pkg::ST_OK;
            oidx_d  = 8'(count_q);
            otok_d  = tok_q;
            oinf_d  = sst_pkg::InfoNone;
            ov_d    = 1'b1;
            ins_d   = 1'b0;
            state_d = sst_pkg::S_IDLE;
          end
        end else begin
          l_we  = 1'b1;
          pos_d = pos_q + 1'b1;
        end
      end

      sst_pkg::S_RD_ENT: begin
        state_d = sst_pkg::S_RD_HEAD;
      end

      sst_pkg::S_RD_HEAD: begin
        if (ent_q.len == ent_q.len && state_q == sst_pkg::S_RD_HEAD) begin
          ent_d = e_rdata;
        end
        if (op_q == sst_pkg::OP_SET_TOK) begin
          ent_d.token = tok_q;
        end else if (op_q == sst_pkg::OP_SET_INF) begin
          ent_d.info = inf_q;
        end
        e_wdata = ent_d;
        if (out_free) begin
          e_we    = (op_q != sst_pkg::OP_READ);
          ost_d   = sst_pkg::ST_OK;
          otok_d  = ent_d.token;
          oinf_d  = ent_d.info;
          och_d   = 8'd0;
          olast_d = (op_q != sst_pkg::OP_READ) || (e_rdata.len == '0);
          ov_d    = 1'b1;
          pos_d   = '0;
          state_d = olast_d ? sst_pkg::S_IDLE : sst_pkg::S_RD_CHAR_RQ;
        end else begin
          state_d = sst_pkg::S_RD_ENT;
        end
      end

      sst_pkg::S_RD_CHAR_RQ: begin
        state_d = sst_pkg::S_RD_CHAR;
      end

      sst_pkg::S_RD_CHAR: begin
        if (out_free) begin
          och_d   = l_rdata;
          olast_d = (LenW'(pos_q) + 1'b1 == ent_q.len)
                    || (pos_q == PosW'(sst_pkg::MaxString - 1));
          ov_d    = 1'b1;
          pos_d   = pos_q + 1'b1;
          state_d = olast_d ? sst_pkg::S_IDLE : sst_pkg::S_RD_CHAR_RQ;
        end else begin
          state_d = sst_pkg::S_RD_CHAR_RQ;
        end
      end

      default: state_d = sst_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sst_pkg::S_IDLE;
      count_q <= '0;
      fill_q  <= '0;
      plen_q  <= '0;
      ins_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      fill_q  <= fill_d;
      plen_q  <= plen_d;
      ins_q   <= ins_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    idx_q   <= idx_d;
    tok_q   <= tok_d;
    inf_q   <= inf_d;
    slen_q  <= slen_d;
    pos_q   <= pos_d;
    ent_q   <= ent_d;
    olast_q <= olast_d;
    ost_q   <= ost_d;
    oidx_q  <= oidx_d;
    och_q   <= och_d;
    otok_q  <= otok_d;
    oinf_q  <= oinf_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tdata  = {5'd0, och_q, oinf_q, otok_q, oidx_q, ost_q};

  // a request is only taken while the sequencer is idle
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> state_q == sst_pkg::S_IDLE)
    else $error("request accepted while busy");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(sst_pkg::TableEntries))
    else $error("entry count overflow");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(sst_pkg::LexemeBytes))
    else $error("lexeme fill overflow");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != $past(count_q) |-> count_q == $past(count_q) + 1'b1)
    else $error("entry count jumped");

endmodule
